// File: src/rcpfa_pkg.sv
// Shared types and constants for the page frame allocator.
package rcpfa_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 16;
   localparam int SHIFT_W = 5;
   localparam int ENTRY_W = COUNT_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT  = 2'd2;

   localparam logic [ADDR_W-1:0]  SEARCH_START_RST = 32'h0000_0000;
   localparam logic [ADDR_W-1:0]  SEARCH_END_RST   = 32'hFFFF_FFFF;
   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST  = 5'd12;

   typedef enum logic [1:0] {
      OP_SET       = 2'd0,
      OP_ALLOC_ANY = 2'd1,
      OP_ALLOC_AT  = 2'd2,
      OP_FREE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_FIRST,
      IDX_SEARCH,
      IDX_NEXT
   } idx_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_CLEAR,
      WR_SET,
      WR_UPDATE
   } wr_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SET,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_RMW_RD,
      S_RMW_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        latch_req;
      idx_sel_type idx_sel;
      logic        mem_rd;
      wr_sel_type  mem_wr;
      logic        rsp_load;
      status_type  rsp_status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   set_outside;
      logic   set_empty;
      logic   tgt_outside;
      logic   scan_empty;
      logic   idx_at_end;
      logic   idx_last;
      logic   frame_free;
      logic   rsp_free;
   } sts_type;

endpackage

// File: src/refcounted_page_frame_allocator.sv
// Reference-counted page frame allocator: one use count and reserved mark per frame.
// Errors and empty ranges skip the table; a set writes each frame of its range,
// allocate-at and free read and rewrite one frame, an allocate scans frames in turn.
// Only one request is in flight; a new one is taken once the result is loaded.
// Reset: config returns to defaults and a clear sweep zeroes the table;
// req_tready stays low until it is done.
module refcounted_page_frame_allocator #(
   parameter int FRAME_COUNT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: opcode, first_address, last_address, new_use_count, new_reserved, pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rcpfa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: frame_address, status, pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rcpfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [rcpfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcpfa_pkg::ADDR_W-1:0]      csr_wdata
);

   rcpfa_pkg::cmd_type cmd;
   rcpfa_pkg::sts_type sts;

   rcpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rcpfa_dp #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> (cmd.mem_wr == rcpfa_pkg::WR_NONE))
      else $error("table read and write in the same cycle");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:32] != 2'd3))
      else $error("undefined status code on result beat");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33:32] != rcpfa_pkg::ST_OK) |-> (rsp_tdata[31:0] == '0))
      else $error("non-zero frame address on failed result");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && rsp_tvalid) |-> rsp_tready)
      else $error("result register overwritten before it was taken");

endmodule

// File: src/rcpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcpfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rcpfa_ctrl.sv
// Controller state machine sequencing table clear, set, scan and update.
module rcpfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rcpfa_pkg::sts_type  sts,
   output rcpfa_pkg::cmd_type  cmd
);

   rcpfa_pkg::state_type  state_ff, state_in;
   rcpfa_pkg::status_type stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcpfa_pkg::S_CLEAR;
         stat_ff  <= rcpfa_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      stat_in        = stat_ff;
      req_tready     = 1'b0;
      cmd.latch_req  = 1'b0;
      cmd.idx_sel    = rcpfa_pkg::IDX_HOLD;
      cmd.mem_rd     = 1'b0;
      cmd.mem_wr     = rcpfa_pkg::WR_NONE;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = stat_ff;

      case (state_ff)
         rcpfa_pkg::S_CLEAR: begin
            cmd.mem_wr = rcpfa_pkg::WR_CLEAR;
            if (sts.idx_last) begin
               state_in = rcpfa_pkg::S_IDLE;
            end else begin
               cmd.idx_sel = rcpfa_pkg::IDX_NEXT;
            end
         end
         rcpfa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = rcpfa_pkg::S_DECODE;
            end
         end
         rcpfa_pkg::S_DECODE: begin
            case (sts.op)
               rcpfa_pkg::OP_SET: begin
                  if (sts.set_outside) begin
                     stat_in  = rcpfa_pkg::ST_OUTSIDE;
                     state_in = rcpfa_pkg::S_RESP;
                  end else if (sts.set_empty) begin
                     stat_in  = rcpfa_pkg::ST_OK;
                     state_in = rcpfa_pkg::S_RESP;
                  end else begin
                     cmd.idx_sel = rcpfa_pkg::IDX_FIRST;
                     state_in    = rcpfa_pkg::S_SET;
                  end
               end
               rcpfa_pkg::OP_ALLOC_ANY: begin
                  if (sts.scan_empty) begin
                     stat_in  = rcpfa_pkg::ST_NO_FREE;
                     state_in = rcpfa_pkg::S_RESP;
                  end else begin
                     cmd.idx_sel = rcpfa_pkg::IDX_SEARCH;
                     state_in    = rcpfa_pkg::S_SCAN_RD;
                  end
               end
               default: begin
                  if (sts.tgt_outside) begin
                     stat_in  = rcpfa_pkg::ST_OUTSIDE;
                     state_in = rcpfa_pkg::S_RESP;
                  end else begin
                     cmd.idx_sel = rcpfa_pkg::IDX_FIRST;
                     state_in    = rcpfa_pkg::S_RMW_RD;
                  end
               end
            endcase
         end
         rcpfa_pkg::S_SET: begin
            cmd.mem_wr = rcpfa_pkg::WR_SET;
            if (sts.idx_at_end) begin
               stat_in  = rcpfa_pkg::ST_OK;
               state_in = rcpfa_pkg::S_RESP;
            end else begin
               cmd.idx_sel = rcpfa_pkg::IDX_NEXT;
            end
         end
         rcpfa_pkg::S_SCAN_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = rcpfa_pkg::S_SCAN_CHK;
         end
         rcpfa_pkg::S_SCAN_CHK: begin
            if (sts.frame_free) begin
               cmd.mem_wr = rcpfa_pkg::WR_UPDATE;
               stat_in    = rcpfa_pkg::ST_OK;
               state_in   = rcpfa_pkg::S_RESP;
            end else if (sts.idx_at_end) begin
               stat_in  = rcpfa_pkg::ST_NO_FREE;
               state_in = rcpfa_pkg::S_RESP;
            end else begin
               cmd.idx_sel = rcpfa_pkg::IDX_NEXT;
               state_in    = rcpfa_pkg::S_SCAN_RD;
            end
         end
         rcpfa_pkg::S_RMW_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = rcpfa_pkg::S_RMW_WR;
         end
         rcpfa_pkg::S_RMW_WR: begin
            cmd.mem_wr = rcpfa_pkg::WR_UPDATE;
            stat_in    = rcpfa_pkg::ST_OK;
            state_in   = rcpfa_pkg::S_RESP;
         end
         rcpfa_pkg::S_RESP: begin
            // wait for the output register to drain
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = rcpfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rcpfa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: src/rcpfa_dp.sv
// Datapath: config registers, request latch, frame index unit, table RAM, result register.
module rcpfa_dp #(
   parameter int FRAME_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rcpfa_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                csr_we,
   input  logic [rcpfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcpfa_pkg::ADDR_W-1:0]        csr_wdata,
   input  rcpfa_pkg::cmd_type                  cmd,
   output rcpfa_pkg::sts_type                  sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcpfa_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IdxW = $clog2(FRAME_COUNT);
   localparam logic [rcpfa_pkg::ADDR_W-1:0] FcLimit = rcpfa_pkg::ADDR_W'(FRAME_COUNT);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_COUNT - 1);
   localparam int CW = rcpfa_pkg::COUNT_W;
   localparam int AW = rcpfa_pkg::ADDR_W;

   // configuration
   logic [AW-1:0]                    start_ff, end_ff;
   logic [rcpfa_pkg::SHIFT_W-1:0]    shift_ff;

   // latched request
   rcpfa_pkg::op_type                op_ff;
   logic [AW-1:0]                    first_ff, last_ff;
   logic [CW-1:0]                    cnt_ff;
   logic                             rsv_ff;

   logic [IdxW-1:0]                  idx_ff, idx_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                    rsp_addr_ff, rsp_addr_in;
   rcpfa_pkg::status_type            rsp_status_ff, rsp_status_in;

   logic [AW-1:0]                    fi32, li32, si32, ei32, base;
   logic [IdxW-1:0]                  ei_clip, bound;
   logic [rcpfa_pkg::ENTRY_W-1:0]    rd_data, wr_data;
   logic [CW-1:0]                    rd_cnt, upd_cnt;
   logic                             rd_rsv;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= rcpfa_pkg::SEARCH_START_RST;
         end_ff   <= rcpfa_pkg::SEARCH_END_RST;
         shift_ff <= rcpfa_pkg::BLOCK_SHIFT_RST;
      end else if (csr_we) begin
         case (csr_index)
            rcpfa_pkg::CSR_SEARCH_START: start_ff <= csr_wdata;
            rcpfa_pkg::CSR_SEARCH_END:   end_ff   <= csr_wdata;
            rcpfa_pkg::CSR_BLOCK_SHIFT:  shift_ff <= csr_wdata[rcpfa_pkg::SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= rcpfa_pkg::op_type'(req_tdata[1:0]);
         first_ff <= req_tdata[33:2];
         last_ff  <= req_tdata[65:34];
         cnt_ff   <= req_tdata[81:66];
         rsv_ff   <= req_tdata[82];
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // frame index of each address of interest
   always_comb begin
      fi32    = first_ff >> shift_ff;
      li32    = last_ff >> shift_ff;
      si32    = start_ff >> shift_ff;
      ei32    = end_ff >> shift_ff;
      ei_clip = (ei32 >= FcLimit) ? LastIdx : ei32[IdxW-1:0];
      bound   = (op_ff == rcpfa_pkg::OP_SET) ? li32[IdxW-1:0] : ei_clip;
      base    = {{(AW-IdxW){1'b0}}, idx_ff} << shift_ff;
   end

   assign rd_cnt = rd_data[CW-1:0];
   assign rd_rsv = rd_data[CW];

   always_comb begin
      sts.op          = op_ff;
      sts.set_outside = (fi32 >= FcLimit) || (li32 >= FcLimit);
      sts.set_empty   = fi32[IdxW-1:0] > li32[IdxW-1:0];
      sts.tgt_outside = fi32 >= FcLimit;
      sts.scan_empty  = (si32 >= FcLimit) || (si32[IdxW-1:0] > ei_clip);
      sts.idx_at_end  = idx_ff == bound;
      sts.idx_last    = idx_ff == LastIdx;
      sts.frame_free  = !rd_rsv && (rd_cnt == '0);
      sts.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      case (cmd.idx_sel)
         rcpfa_pkg::IDX_FIRST:  idx_in = fi32[IdxW-1:0];
         rcpfa_pkg::IDX_SEARCH: idx_in = si32[IdxW-1:0];
         rcpfa_pkg::IDX_NEXT:   idx_in = IdxW'(idx_ff + 1'b1);
         default:               idx_in = idx_ff;
      endcase
   end

   // count update for allocate and free, saturating both ways
   always_comb begin
      case (op_ff)
         rcpfa_pkg::OP_ALLOC_ANY: upd_cnt = CW'(1);
         rcpfa_pkg::OP_ALLOC_AT:
            upd_cnt = (rd_cnt == rcpfa_pkg::COUNT_MAX) ? rd_cnt : CW'(rd_cnt + 1'b1);
         rcpfa_pkg::OP_FREE:
            upd_cnt = (rd_cnt == '0) ? rd_cnt : CW'(rd_cnt - 1'b1);
         default: upd_cnt = rd_cnt;
      endcase
   end

   always_comb begin
      case (cmd.mem_wr)
         rcpfa_pkg::WR_SET:    wr_data = {rsv_ff, cnt_ff};
         rcpfa_pkg::WR_UPDATE: wr_data = {rd_rsv, upd_cnt};
         default:              wr_data = '0;
      endcase
   end

   rcpfa_ram #(
      .WIDTH (rcpfa_pkg::ENTRY_W),
      .DEPTH (FRAME_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.mem_wr != rcpfa_pkg::WR_NONE),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_addr_in   = (cmd.rsp_status == rcpfa_pkg::ST_OK && op_ff != rcpfa_pkg::OP_SET)
                         ? base : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_addr_ff};

endmodule

// File: tb/refcounted_page_frame_allocator_tb.sv
// Self-checking testbench for the page frame allocator: directed table, then random traffic.
module refcounted_page_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_COUNT  = 1024;
   localparam int SUB_ITEMS    = 71;
   localparam int RANDOM_ITEMS = 3 * 4 * SUB_ITEMS;
   // worst case per item: a full-table scan plus long gaps on both sides, doubled
   localparam int CYCLE_LIMIT  =
      2 * (RANDOM_ITEMS + 40) * (2 * FRAME_COUNT + 3 + 200) + 4 * FRAME_COUNT;

   // index with no register behind it; writes to it must change nothing
   localparam logic [rcpfa_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [rcpfa_pkg::ADDR_W-1:0] addr;
      rcpfa_pkg::status_type        st;
   } frame_reply_type;

   typedef struct packed {
      logic [rcpfa_pkg::ADDR_W-1:0]  lo_addr;
      logic [rcpfa_pkg::ADDR_W-1:0]  hi_addr;
      logic [rcpfa_pkg::SHIFT_W-1:0] shift;
   } window_type;

   typedef struct packed {
      logic [2:0]                    setting;
      rcpfa_pkg::op_type             op;
      logic [rcpfa_pkg::ADDR_W-1:0]  first;
      logic [rcpfa_pkg::ADDR_W-1:0]  last;
      logic [rcpfa_pkg::COUNT_W-1:0] count;
      logic                          rsv;
      logic                          typed;
      logic [rcpfa_pkg::ADDR_W-1:0]  want_addr;
      rcpfa_pkg::status_type         want_st;
   } dir_row_type;

   localparam window_type DIR_WINDOWS [6] = '{
      '{'h0000_0000, 'hFFFF_FFFF, 5'd12},
      '{'h0000_1800, 'hFFFF_FFFF, 5'd12},
      '{'h0040_0000, 'hFFFF_FFFF, 5'd12},
      '{'h0000_5000, 'h0000_3000, 5'd12},
      '{'h0000_0000, 'hFFFF_FFFF, 5'd31},
      '{'h0000_0000, 'h0000_0003, 5'd0}
   };

   // setting, op, first, last, count, reserved, typed, address, status
   localparam dir_row_type DIRECTED [26] = '{
      '{3'd0, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h1000, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_FREE, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_FREE, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_ALLOC_AT, 'hFFF, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_SET, 'h2000, 'h3FFF, 'h0, 1'b1,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h4000, rcpfa_pkg::ST_OK},
      // reversed range writes nothing
      '{3'd0, rcpfa_pkg::OP_SET, 'h5000, 'h4000, 'h5, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_SET, 'h40_0000, 'h40_0000, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OUTSIDE},
      '{3'd0, rcpfa_pkg::OP_SET, 'h0, 'hFFFF_FFFF, 'hFFFF, 1'b1,
        1'b1, 'h0, rcpfa_pkg::ST_OUTSIDE},
      '{3'd0, rcpfa_pkg::OP_ALLOC_AT, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF, 1'b1,
        1'b1, 'h0, rcpfa_pkg::ST_OUTSIDE},
      '{3'd0, rcpfa_pkg::OP_FREE, 'h40_0000, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OUTSIDE},
      '{3'd0, rcpfa_pkg::OP_SET, 'h3F_F000, 'h3F_FFFF, 'hFFFF, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      // count already at its ceiling
      '{3'd0, rcpfa_pkg::OP_ALLOC_AT, 'h3F_F123, 'h0, 'h0, 1'b0,
        1'b1, 'h3F_F000, rcpfa_pkg::ST_OK},
      // allocate-at goes through a reserved frame
      '{3'd0, rcpfa_pkg::OP_ALLOC_AT, 'h2000, 'h0, 'h0, 1'b0,
        1'b1, 'h2000, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_SET, 'h0, 'h3F_FFFF, 'h1, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd0, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_NO_FREE},
      '{3'd0, rcpfa_pkg::OP_SET, 'h0, 'h3F_FFFF, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      // unaligned window start hands out the frame base below it
      '{3'd1, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h1000, rcpfa_pkg::ST_OK},
      '{3'd2, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_NO_FREE},
      '{3'd3, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_NO_FREE},
      '{3'd4, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OK},
      '{3'd4, rcpfa_pkg::OP_ALLOC_AT, 'hFFFF_FFFF, 'h0, 'h0, 1'b0,
        1'b1, 'h8000_0000, rcpfa_pkg::ST_OK},
      '{3'd5, rcpfa_pkg::OP_ALLOC_ANY, 'h0, 'h0, 'h0, 1'b0,
        1'b0, 'h0, rcpfa_pkg::ST_OK},
      '{3'd5, rcpfa_pkg::OP_ALLOC_AT, 'h3FF, 'h0, 'h0, 1'b0,
        1'b1, 'h3FF, rcpfa_pkg::ST_OK},
      '{3'd5, rcpfa_pkg::OP_FREE, 'h400, 'h0, 'h0, 1'b0,
        1'b1, 'h0, rcpfa_pkg::ST_OUTSIDE}
   };

   localparam int SEND_IDLE [3] = '{37, 45, 0};
   localparam int RECV_IDLE [3] = '{45, 37, 0};

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [rcpfa_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [rcpfa_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                 csr_we     = 1'b0;
   logic [rcpfa_pkg::CSR_IDX_W-1:0]      csr_index  = '0;
   logic [rcpfa_pkg::ADDR_W-1:0]         csr_wdata  = '0;

   // mirror of the block's registers and frame table
   logic [rcpfa_pkg::ADDR_W-1:0]  start_q;
   logic [rcpfa_pkg::ADDR_W-1:0]  stop_q;
   logic [rcpfa_pkg::SHIFT_W-1:0] shift_q;
   logic [rcpfa_pkg::COUNT_W-1:0] use_count_q [FRAME_COUNT];
   logic                          reserved_q  [FRAME_COUNT];

   frame_reply_type replies_due[$];
   int cycle_count   = 0;
   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int reg_writes    = 0;
   int no_free_seen  = 0;
   int outside_seen  = 0;
   int op_seen [4]   = '{0, 0, 0, 0};

   refcounted_page_frame_allocator #(
      .FRAME_COUNT(FRAME_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5ns clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, replies_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_error(string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic frame_reply_type frame_table_step(
      rcpfa_pkg::op_type op, logic [rcpfa_pkg::ADDR_W-1:0] first,
      logic [rcpfa_pkg::ADDR_W-1:0] last, logic [rcpfa_pkg::COUNT_W-1:0] count, logic rsv);
      frame_reply_type              r;
      logic [rcpfa_pkg::ADDR_W-1:0] fi;
      logic [rcpfa_pkg::ADDR_W-1:0] li;
      logic [rcpfa_pkg::ADDR_W-1:0] si;
      logic [rcpfa_pkg::ADDR_W-1:0] ei;
      logic                         hit;
      r.addr = '0;
      r.st   = rcpfa_pkg::ST_OK;
      fi = first >> shift_q;
      li = last >> shift_q;
      case (op)
         rcpfa_pkg::OP_SET: begin
            if (fi >= FRAME_COUNT || li >= FRAME_COUNT) begin
               r.st = rcpfa_pkg::ST_OUTSIDE;
            end else begin
               for (int i = int'(fi); i <= int'(li); i++) begin
                  use_count_q[i] = count;
                  reserved_q[i]  = rsv;
               end
            end
         end
         rcpfa_pkg::OP_ALLOC_ANY: begin
            si  = start_q >> shift_q;
            ei  = stop_q >> shift_q;
            hit = 1'b0;
            if (ei >= FRAME_COUNT) ei = FRAME_COUNT - 1;
            if (si < FRAME_COUNT) begin
               for (int i = int'(si); i <= int'(ei) && !hit; i++) begin
                  if (!reserved_q[i] && use_count_q[i] == '0) begin
                     use_count_q[i] = 16'd1;
                     r.addr = 32'(i) << shift_q;
                     hit = 1'b1;
                  end
               end
            end
            if (!hit) r.st = rcpfa_pkg::ST_NO_FREE;
         end
         default: begin
            if (fi >= FRAME_COUNT) begin
               r.st = rcpfa_pkg::ST_OUTSIDE;
            end else begin
               if (op == rcpfa_pkg::OP_ALLOC_AT) begin
                  if (use_count_q[fi] != rcpfa_pkg::COUNT_MAX) use_count_q[fi]++;
               end else if (use_count_q[fi] != '0) begin
                  use_count_q[fi]--;
               end
               r.addr = fi << shift_q;
            end
         end
      endcase
      return r;
   endfunction

   // table addresses, often near the window start; some just past the table, some random
   function automatic logic [rcpfa_pkg::ADDR_W-1:0] pick_address();
      logic [rcpfa_pkg::ADDR_W:0]   low_mask;
      logic [rcpfa_pkg::ADDR_W-1:0] idx;
      int                           mode;
      low_mask = (33'd1 << shift_q) - 33'd1;
      mode = $urandom_range(0, 9);
      if (mode >= 8) return $urandom();
      if (mode < 4) idx = (start_q >> shift_q) + $urandom_range(0, 40);
      else if (mode < 7) idx = $urandom_range(0, FRAME_COUNT - 1);
      else idx = FRAME_COUNT + $urandom_range(0, 3);
      return (idx << shift_q) | ($urandom() & low_mask[rcpfa_pkg::ADDR_W-1:0]);
   endfunction

   task automatic send_request(rcpfa_pkg::op_type op, logic [rcpfa_pkg::ADDR_W-1:0] first,
                               logic [rcpfa_pkg::ADDR_W-1:0] last,
                               logic [rcpfa_pkg::COUNT_W-1:0] count, logic rsv, logic typed,
                               frame_reply_type typed_reply);
      frame_reply_type predicted;
      frame_reply_type due;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, rsv, count, last, first, op};
      do @(posedge clock); while (!req_tready);
      predicted = frame_table_step(op, first, last, count, rsv);
      due = typed ? typed_reply : predicted;
      replies_due.push_back(due);
      op_seen[int'(op)]++;
      if (due.st == rcpfa_pkg::ST_NO_FREE) no_free_seen++;
      if (due.st == rcpfa_pkg::ST_OUTSIDE) outside_seen++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (replies_due.size() != 0);
   endtask

   task automatic write_reg(logic [rcpfa_pkg::CSR_IDX_W-1:0] idx,
                            logic [rcpfa_pkg::ADDR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         rcpfa_pkg::CSR_SEARCH_START: start_q = value;
         rcpfa_pkg::CSR_SEARCH_END:   stop_q  = value;
         rcpfa_pkg::CSR_BLOCK_SHIFT:  shift_q = value[rcpfa_pkg::SHIFT_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   task automatic apply_window(window_type w);
      wait_drained();
      write_reg(rcpfa_pkg::CSR_SEARCH_START, w.lo_addr);
      write_reg(rcpfa_pkg::CSR_SEARCH_END, w.hi_addr);
      // junk above the shift field is dropped by the register
      write_reg(rcpfa_pkg::CSR_BLOCK_SHIFT, ($urandom() & ~32'h1F) | 32'(w.shift));
      write_reg(CSR_SPARE, $urandom());
      csr_we <= 1'b0;
   endtask

   initial begin
      int                            cur_setting;
      int                            pick;
      window_type                    w;
      logic [rcpfa_pkg::ADDR_W:0]    low_mask;
      rcpfa_pkg::op_type             op;
      logic [rcpfa_pkg::ADDR_W-1:0]  first;
      logic [rcpfa_pkg::ADDR_W-1:0]  last;
      logic [rcpfa_pkg::COUNT_W-1:0] count;
      logic                          rsv;

      start_q = rcpfa_pkg::SEARCH_START_RST;
      stop_q  = rcpfa_pkg::SEARCH_END_RST;
      shift_q = rcpfa_pkg::BLOCK_SHIFT_RST;
      foreach (use_count_q[i]) begin
         use_count_q[i] = '0;
         reserved_q[i]  = 1'b0;
      end
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      cur_setting = 0;
      foreach (DIRECTED[r]) begin
         if (int'(DIRECTED[r].setting) != cur_setting) begin
            cur_setting = DIRECTED[r].setting;
            apply_window(DIR_WINDOWS[cur_setting]);
         end
         send_request(DIRECTED[r].op, DIRECTED[r].first, DIRECTED[r].last, DIRECTED[r].count,
                      DIRECTED[r].rsv, DIRECTED[r].typed,
                      '{DIRECTED[r].want_addr, DIRECTED[r].want_st});
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         recv_idle_pct = RECV_IDLE[phase];
         for (int sub = 0; sub < 4; sub++) begin
            case ($urandom_range(0, 3))
               0: w.shift = 5'd0;
               1: w.shift = 5'd31;
               2: w.shift = 5'd12;
               default: w.shift = 5'($urandom_range(0, 31));
            endcase
            low_mask = (33'd1 << w.shift) - 33'd1;
            case ($urandom_range(0, 5))
               0: begin
                  w.lo_addr = '0;
                  w.hi_addr = '1;
               end
               1: begin
                  w.lo_addr = $urandom();
                  w.hi_addr = $urandom();
               end
               2: begin
                  w.lo_addr = '1;
                  w.hi_addr = '0;
               end
               default: begin
                  // narrow window keeps the allocate scans short
                  w.lo_addr = (32'($urandom_range(0, FRAME_COUNT - 1)) << w.shift)
                              | ($urandom() & low_mask[rcpfa_pkg::ADDR_W-1:0]);
                  w.hi_addr = w.lo_addr + (32'($urandom_range(0, 63)) << w.shift);
               end
            endcase
            apply_window(w);

            for (int n = 0; n < SUB_ITEMS; n++) begin
               if ($urandom_range(0, 39) == 0) wait_drained();
               pick  = $urandom_range(0, 99);
               op    = pick < 25 ? rcpfa_pkg::OP_SET :
                       pick < 55 ? rcpfa_pkg::OP_ALLOC_ANY :
                       pick < 80 ? rcpfa_pkg::OP_ALLOC_AT : rcpfa_pkg::OP_FREE;
               first = pick_address();
               last  = $urandom();
               count = 16'($urandom_range(0, 65535));
               rsv   = 1'($urandom_range(0, 1));
               if (op == rcpfa_pkg::OP_SET) begin
                  if ($urandom_range(0, 9) != 0)
                     last = first + (32'($urandom_range(0, 7)) << shift_q);
                  pick  = $urandom_range(0, 9);
                  if (pick < 6) count = '0;
                  else if (pick < 8) count = 16'($urandom_range(1, 3));
                  rsv   = ($urandom_range(0, 4) == 0);
               end
               send_request(op, first, last, count, rsv, 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests: set %0d, allocate %0d, allocate-at %0d, free %0d",
               op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
               op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("%0d no-free and %0d out-of-table replies, %0d register writes, %0d errors",
               no_free_seen, outside_seen, reg_writes, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            report_error($sformatf("reply beat %h with nothing outstanding", rsp_tdata));
         end else begin
            want = replies_due.pop_front();
            if (rsp_tdata[rcpfa_pkg::ADDR_W-1:0] !== want.addr)
               report_error($sformatf("frame_address %h, expected %h",
                                      rsp_tdata[rcpfa_pkg::ADDR_W-1:0], want.addr));
            if (rsp_tdata[rcpfa_pkg::ADDR_W+1:rcpfa_pkg::ADDR_W] !== want.st)
               report_error($sformatf("status %0d, expected %0d",
                                      rsp_tdata[rcpfa_pkg::ADDR_W+1:rcpfa_pkg::ADDR_W],
                                      want.st));
         end
      end
   end

endmodule
